[design/ftarc_pkg.sv]
`default_nettype none
package ftarc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIMER_W         = 24;
    localparam int TMO_W           = 23;
    localparam int RETRY_W         = 3;
    localparam int SEQ_W           = 8;
    localparam int CLASS_W         = 2;
    localparam int ENTRY_W         = SEQ_W + 1 + CLASS_W;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = TMO_W;

    localparam logic [TMO_W-1:0]   SEND_TMO_RST    = TMO_W'(4000);
    localparam logic [TMO_W-1:0]   ACK_TMO_RST     = TMO_W'(60);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = RETRY_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_SEND_TMO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd2;

    typedef enum logic [1:0] {
        FUNC_POLL    = 2'd0,
        FUNC_ENQUEUE = 2'd1,
        FUNC_ACK     = 2'd2,
        FUNC_WON     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_RELOAD = 2'd2,
        ACT_REPORT = 2'd3
    } t_action;

    localparam logic [1:0] STAT_SUCCESS  = 2'd0;
    localparam logic [1:0] STAT_NOT_SENT = 2'd1;
    localparam logic [1:0] STAT_NO_ACK   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [TIMER_W-1:0] now;
        logic [SEQ_W-1:0]   seq_num;
        logic               want_ack;
        logic [CLASS_W-1:0] frame_class;
    } t_req;

    typedef struct packed {
        logic [1:0]         action;
        logic [SEQ_W-1:0]   out_seq;
        logic [CLASS_W-1:0] out_class;
        logic               out_want_ack;
        logic [1:0]         tx_status;
        logic               clear_radio;
        logic               queue_dropped;
    } t_res;

endpackage
`default_nettype wire

[design/ftarc_req_if.sv]
`default_nettype none
interface ftarc_req_if;
    import ftarc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/ftarc_res_if.sv]
`default_nettype none
interface ftarc_res_if;
    import ftarc_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/ftarc_ram.sv]
`default_nettype none
module ftarc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/frame_tx_ack_retry_controller_top.sv]
// frame transmit ack and retry controller
// i_req carries one event per request: poll, enqueue, ack received or
// channel won, with the current 24-bit timer value. o_res returns exactly
// one result per request: an action (nothing, load, reload, report) with
// the frame descriptor, status, clear-radio and queue-dropped flags.
// pending frames sit in a queue memory with a registered read; the head
// entry is read at the accept edge and the event is resolved in the
// execute state once the output register is free, so a new request is
// only accepted after the previous one has been resolved.
// a new request is accepted while a finished result still waits in the
// output register; if the receiver stalls, the pending request waits in
// its execute cycle until the output register frees, and i_req.ready
// stays low meanwhile.
// configuration writes (send timeout, ack timeout, retry limit) are taken
// at any edge with i_cfg_wr_en high and must be made while idle.
// synchronous reset empties the queue, sets the transmitter idle with no
// frame in flight and restores the register defaults; no memory clearing
// is needed since only written queue slots are read.
`default_nettype none
module frame_tx_ack_retry_controller_top #(
    parameter int QUEUE_DEPTH = ftarc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [ftarc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ftarc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    ftarc_req_if.sink                                i_req,
    ftarc_res_if.source                              o_res
);
    import ftarc_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_SENT    = 2'd2;

    typedef enum logic {
        ST_WAIT,
        ST_EXEC
    } t_state;

    t_state               r_state;
    t_req                 r_item;
    logic [TMO_W-1:0]     r_send_tmo;
    logic [TMO_W-1:0]     r_ack_tmo;
    logic [RETRY_W-1:0]   r_max_retries;
    logic [1:0]           r_phase,      n_phase;
    logic [IDX_W-1:0]     r_head,       n_head;
    logic [IDX_W-1:0]     r_tail,       n_tail;
    logic [CNT_W-1:0]     r_count,      n_count;
    logic                 r_inf_valid,  n_inf_valid;
    logic [SEQ_W-1:0]     r_inf_seq,    n_inf_seq;
    logic [CLASS_W-1:0]   r_inf_class,  n_inf_class;
    logic [TIMER_W-1:0]   r_stamp,      n_stamp;
    logic [RETRY_W-1:0]   r_retry,      n_retry;
    logic                 r_out_valid;
    t_res                 r_out,        n_out;

    logic                 req_fire;
    logic                 exec_go;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [TMO_W-1:0]     tmo_sel;
    logic [TIMER_W-1:0]   deadline;
    logic [TIMER_W-1:0]   delta;
    logic                 expired;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_WAIT);
    assign exec_go     = (r_state == ST_EXEC) && (!r_out_valid || o_res.ready);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign ram_wdata = {r_item.seq_num, r_item.want_ack, r_item.frame_class};

    ftarc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // modular timeout test on the 24-bit timer
    assign tmo_sel  = (r_phase == PH_SENDING) ? r_send_tmo : r_ack_tmo;
    assign deadline = r_stamp + TIMER_W'(tmo_sel);
    assign delta    = r_item.now - deadline;
    assign expired  = !delta[TIMER_W-1];

    always_comb begin
        n_phase     = r_phase;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_inf_valid = r_inf_valid;
        n_inf_seq   = r_inf_seq;
        n_inf_class = r_inf_class;
        n_stamp     = r_stamp;
        n_retry     = r_retry;
        n_out       = '0;
        ram_we      = 1'b0;
        case (r_item.func)
            FUNC_POLL: begin
                if ((r_phase == PH_SENDING || r_phase == PH_SENT) && expired) begin
                    if (!r_inf_valid) begin
                        n_phase           = PH_IDLE;
                        n_out.clear_radio = 1'b1;
                    end else if (r_retry < r_max_retries) begin
                        n_stamp            = r_item.now;
                        n_retry            = r_retry + 1'b1;
                        n_phase            = PH_SENDING;
                        n_out.action       = ACT_RELOAD;
                        n_out.out_seq      = r_inf_seq;
                        n_out.out_class    = r_inf_class;
                        n_out.out_want_ack = 1'b1;
                    end else begin
                        n_out.action      = ACT_REPORT;
                        n_out.out_seq     = r_inf_seq;
                        n_out.out_class   = r_inf_class;
                        n_out.tx_status   = (r_phase == PH_SENDING) ? STAT_NOT_SENT
                                                                    : STAT_NO_ACK;
                        n_out.clear_radio = 1'b1;
                        n_inf_valid       = 1'b0;
                        n_phase           = PH_IDLE;
                    end
                end else if (r_phase != PH_SENDING && r_phase != PH_SENT &&
                             r_count != '0) begin
                    n_head             = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : r_head + 1'b1;
                    n_count            = r_count - 1'b1;
                    n_phase            = PH_SENDING;
                    n_stamp            = r_item.now;
                    n_retry            = '0;
                    n_inf_valid        = ram_rdata[CLASS_W];
                    n_inf_seq          = ram_rdata[ENTRY_W-1:CLASS_W+1];
                    n_inf_class        = ram_rdata[CLASS_W-1:0];
                    n_out.action       = ACT_LOAD;
                    n_out.out_seq      = ram_rdata[ENTRY_W-1:CLASS_W+1];
                    n_out.out_class    = ram_rdata[CLASS_W-1:0];
                    n_out.out_want_ack = ram_rdata[CLASS_W];
                end
            end
            FUNC_ENQUEUE: begin
                if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    n_out.queue_dropped = 1'b1;
                end else begin
                    ram_we  = exec_go;
                    n_tail  = (r_tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_ACK: begin
                if (r_inf_valid && r_inf_seq == r_item.seq_num) begin
                    n_out.action      = ACT_REPORT;
                    n_out.out_seq     = r_inf_seq;
                    n_out.out_class   = r_inf_class;
                    n_out.tx_status   = STAT_SUCCESS;
                    n_out.clear_radio = 1'b1;
                    n_inf_valid       = 1'b0;
                    n_phase           = PH_IDLE;
                end
            end
            default: begin
                n_phase = r_inf_valid ? PH_SENT : PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_WAIT;
            r_item        <= '0;
            r_send_tmo    <= SEND_TMO_RST;
            r_ack_tmo     <= ACK_TMO_RST;
            r_max_retries <= MAX_RETRIES_RST;
            r_phase       <= PH_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_inf_valid   <= 1'b0;
            r_inf_seq     <= '0;
            r_inf_class   <= '0;
            r_stamp       <= '0;
            r_retry       <= '0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SEND_TMO:    r_send_tmo    <= i_cfg_wdata[TMO_W-1:0];
                    CFG_ACK_TMO:     r_ack_tmo     <= i_cfg_wdata[TMO_W-1:0];
                    CFG_MAX_RETRIES: r_max_retries <= i_cfg_wdata[RETRY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (o_res.ready && !exec_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_WAIT: begin
                    if (req_fire) begin
                        r_item  <= i_req.data;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_go) begin
                        r_phase     <= n_phase;
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_count     <= n_count;
                        r_inf_valid <= n_inf_valid;
                        r_inf_seq   <= n_inf_seq;
                        r_inf_class <= n_inf_class;
                        r_stamp     <= n_stamp;
                        r_retry     <= n_retry;
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_WAIT;
                    end
                end
                default: r_state <= ST_WAIT;
            endcase
        end
    end
endmodule
`default_nettype wire

[verif/ftarc_tx_checker.sv]
`timescale 1ns / 100ps
module ftarc_tx_checker
    import ftarc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ftarc_req_if                  i_req,
    ftarc_res_if                  i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int QDEPTH = QUEUE_DEPTH_DEF;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_SENT    = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic               want;
        logic [CLASS_W-1:0] cls;
    } t_frame;

    logic [TMO_W-1:0]   send_tmo;
    logic [TMO_W-1:0]   ack_tmo;
    logic [RETRY_W-1:0] retry_limit;

    logic [1:0]         tx_phase;
    t_frame             frame_mem [QDEPTH];
    int                 frame_head;
    int                 frame_tail;
    int                 frame_count;
    logic               fly_valid;
    logic [SEQ_W-1:0]   fly_seq;
    logic [CLASS_W-1:0] fly_class;
    logic [TIMER_W-1:0] stamp;
    logic [RETRY_W-1:0] retries_used;

    t_res action_due_q [$];
    int   fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic timer_expired(input logic [TIMER_W-1:0] now,
                                           input logic [TMO_W-1:0] tmo);
        logic [TIMER_W-1:0] deadline;
        logic [TIMER_W-1:0] delta;
        deadline = stamp + TIMER_W'(tmo);
        delta = now - deadline;
        return delta < 24'h800000;
    endfunction

    function automatic void handle_timeout(input logic [TIMER_W-1:0] now,
                                           input logic [1:0] fail_stat,
                                           inout t_res r);
        if (!fly_valid) begin
            tx_phase = PH_IDLE;
            r.clear_radio = 1'b1;
        end else if (retries_used < retry_limit) begin
            stamp = now;
            retries_used = retries_used + 1'b1;
            tx_phase = PH_SENDING;
            r.action = ACT_RELOAD;
            r.out_seq = fly_seq;
            r.out_class = fly_class;
            r.out_want_ack = 1'b1;
        end else begin
            r.action = ACT_REPORT;
            r.out_seq = fly_seq;
            r.out_class = fly_class;
            r.tx_status = fail_stat;
            r.clear_radio = 1'b1;
            fly_valid = 1'b0;
            tx_phase = PH_IDLE;
        end
    endfunction

    function automatic t_res predict_tx_action(input t_req q);
        t_res r;
        t_frame f;
        r = '0;
        case (q.func)
            FUNC_POLL: begin
                if (tx_phase == PH_SENDING) begin
                    if (timer_expired(q.now, send_tmo))
                        handle_timeout(q.now, STAT_NOT_SENT, r);
                end else if (tx_phase == PH_SENT) begin
                    if (timer_expired(q.now, ack_tmo))
                        handle_timeout(q.now, STAT_NO_ACK, r);
                end else if (frame_count != 0) begin
                    f = frame_mem[frame_head];
                    frame_head = (frame_head == QDEPTH - 1) ? 0 : frame_head + 1;
                    frame_count--;
                    tx_phase = PH_SENDING;
                    stamp = q.now;
                    retries_used = '0;
                    fly_valid = f.want;
                    fly_seq = f.seq;
                    fly_class = f.cls;
                    r.action = ACT_LOAD;
                    r.out_seq = f.seq;
                    r.out_class = f.cls;
                    r.out_want_ack = f.want;
                end
            end
            FUNC_ENQUEUE: begin
                if (frame_count >= QDEPTH) begin
                    r.queue_dropped = 1'b1;
                end else begin
                    frame_mem[frame_tail] = '{q.seq_num, q.want_ack, q.frame_class};
                    frame_tail = (frame_tail == QDEPTH - 1) ? 0 : frame_tail + 1;
                    frame_count++;
                end
            end
            FUNC_ACK: begin
                if (fly_valid && fly_seq == q.seq_num) begin
                    r.action = ACT_REPORT;
                    r.out_seq = fly_seq;
                    r.out_class = fly_class;
                    r.tx_status = STAT_SUCCESS;
                    r.clear_radio = 1'b1;
                    fly_valid = 1'b0;
                    tx_phase = PH_IDLE;
                end
            end
            default: begin
                tx_phase = fly_valid ? PH_SENT : PH_IDLE;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res due;
        t_res got;
        if (!i_rst_n) begin
            send_tmo = SEND_TMO_RST;
            ack_tmo = ACK_TMO_RST;
            retry_limit = MAX_RETRIES_RST;
            tx_phase = PH_IDLE;
            frame_head = 0;
            frame_tail = 0;
            frame_count = 0;
            fly_valid = 1'b0;
            fly_seq = '0;
            fly_class = '0;
            stamp = '0;
            retries_used = '0;
            action_due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SEND_TMO:    send_tmo = i_cfg_wdata[TMO_W-1:0];
                    CFG_ACK_TMO:     ack_tmo = i_cfg_wdata[TMO_W-1:0];
                    CFG_MAX_RETRIES: retry_limit = i_cfg_wdata[RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (action_due_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with no request pending: act=%0d seq=%0h",
                                 $time, got.action, got.out_seq);
                    fail_count++;
                end else begin
                    due = action_due_q.pop_front();
                    if (got.action != due.action || got.out_seq != due.out_seq ||
                        got.out_class != due.out_class ||
                        got.out_want_ack != due.out_want_ack ||
                        got.tx_status != due.tx_status ||
                        got.clear_radio != due.clear_radio ||
                        got.queue_dropped != due.queue_dropped) begin
                        if (fail_count < 10) begin
                            $display("%0t: mismatch exp act=%0d seq=%0h cls=%0d ack=%0d",
                                     $time, due.action, due.out_seq, due.out_class,
                                     due.out_want_ack, " st=%0d clr=%0d drop=%0d",
                                     due.tx_status, due.clear_radio, due.queue_dropped);
                            $display("%0t:          got act=%0d seq=%0h cls=%0d ack=%0d",
                                     $time, got.action, got.out_seq, got.out_class,
                                     got.out_want_ack, " st=%0d clr=%0d drop=%0d",
                                     got.tx_status, got.clear_radio, got.queue_dropped);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                action_due_q.push_back(predict_tx_action(i_req.data));
        end
        o_pending = action_due_q.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import ftarc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 325;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    ftarc_req_if req_ch ();
    ftarc_res_if res_ch ();

    int fail_n;
    int pending_n;
    int cycle_n = 0;
    int src_idle_pct = 0;
    int rcv_stall_pct = 0;

    int unsigned        send_v;
    int unsigned        ack_v;
    logic [TIMER_W-1:0] tnow;
    logic [SEQ_W-1:0]   seq_guess_q [$];

    frame_tx_ack_retry_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    ftarc_tx_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_n),
        .o_pending    (pending_n)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("[frame_tx_ack_retry_controller_top] ERROR");
            $finish;
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // returns right after the accepting edge
    task automatic send_req(input t_func f, input logic [TIMER_W-1:0] now,
                            input logic [SEQ_W-1:0] seq, input logic want,
                            input logic [CLASS_W-1:0] cls);
        t_req r;
        r.func = f;
        r.now = now;
        r.seq_num = seq;
        r.want_ack = want;
        r.frame_class = cls;
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_n != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic enqueue_frame();
        logic [SEQ_W-1:0] s;
        s = SEQ_W'($urandom);
        send_req(FUNC_ENQUEUE, TIMER_W'($urandom), s, $urandom_range(99) < 85,
                 CLASS_W'($urandom));
        if (seq_guess_q.size() < QUEUE_DEPTH_DEF)
            seq_guess_q.push_back(s);
    endtask

    initial begin
        int n;
        int k;
        int c;
        int span;
        int unsigned retr_v;
        bit paused;
        logic [SEQ_W-1:0] cur_seq;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        send_v = 4000;
        ack_v = 60;
        tnow = '0;
        cur_seq = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue, stray ack and won with nothing in flight
        send_req(FUNC_POLL, 24'h000000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_ACK, 24'h000000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_WON, 24'h000000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_ENQUEUE, 24'hffffff, 8'hff, 1'b1, 2'd3);
        send_req(FUNC_ENQUEUE, 24'h000000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_ENQUEUE, 24'h000000, 8'h55, 1'b1, 2'd1);
        send_req(FUNC_ENQUEUE, 24'h000000, 8'haa, 1'b1, 2'd2);
        // load across the timer wrap, then ack timeout and matching ack
        send_req(FUNC_POLL, 24'hffffff, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'h000000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_WON, 24'h000001, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_ACK, 24'h000001, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd59, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_WON, 24'd60, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_ACK, 24'd61, 8'hff, 1'b0, 2'd0);
        // frame without ack request times out silently
        send_req(FUNC_POLL, 24'd100, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd4100, 8'h00, 1'b0, 2'd0);
        // send timeouts until retries run out
        send_req(FUNC_POLL, 24'd5000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd9000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd13000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd17000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd21000, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd21001, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_WON, 24'd21002, 8'h00, 1'b0, 2'd0);
        send_req(FUNC_POLL, 24'd21061, 8'h00, 1'b0, 2'd0);
        tnow = 24'd21100;

        for (int p = 0; p < 5; p++) begin
            drain_results();
            case (p)
                0: begin
                    send_v = 1; ack_v = 1; retr_v = 0;
                    src_idle_pct = 0; rcv_stall_pct = 0;
                end
                1: begin
                    send_v = 8388607; ack_v = 8388607; retr_v = 7;
                    src_idle_pct = 47; rcv_stall_pct = 0;
                end
                2: begin
                    send_v = 300; ack_v = 60; retr_v = 3;
                    src_idle_pct = 0; rcv_stall_pct = 47;
                end
                3: begin
                    send_v = $urandom_range(1, 2000); ack_v = $urandom_range(1, 500);
                    retr_v = $urandom_range(7);
                    src_idle_pct = 29; rcv_stall_pct = 29;
                end
                default: begin
                    send_v = 4000; ack_v = 60; retr_v = 3;
                    src_idle_pct = 0; rcv_stall_pct = 0;
                end
            endcase
            write_reg(CFG_SEND_TMO, send_v);
            write_reg(CFG_ACK_TMO, ack_v);
            write_reg(CFG_MAX_RETRIES, retr_v);

            n = 0;
            paused = 1'b0;
            while (n < PHASE_ITEMS) begin
                if (!paused && n >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_results();
                end
                c = $urandom_range(99);
                if (c < 12) begin
                    send_req(t_func'($urandom_range(3)), TIMER_W'($urandom),
                             SEQ_W'($urandom), 1'($urandom), CLASS_W'($urandom));
                    n++;
                end else if (c < 16) begin
                    // overfill the queue
                    k = $urandom_range(17, 20);
                    repeat (k) begin
                        enqueue_frame();
                        n++;
                    end
                end else begin
                    k = $urandom_range(1, 3);
                    repeat (k) begin
                        enqueue_frame();
                        n++;
                    end
                    repeat (k) begin
                        tnow = tnow + TIMER_W'($urandom_range(3));
                        send_req(FUNC_POLL, tnow, SEQ_W'($urandom), 1'($urandom),
                                 CLASS_W'($urandom));
                        n++;
                        if (seq_guess_q.size() != 0)
                            cur_seq = seq_guess_q.pop_front();
                        repeat ($urandom_range(1, 8)) begin
                            c = $urandom_range(99);
                            tnow = tnow + TIMER_W'($urandom_range(3));
                            if (c < 25) begin
                                send_req(FUNC_WON, tnow, SEQ_W'($urandom), 1'($urandom),
                                         CLASS_W'($urandom));
                            end else if (c < 45) begin
                                send_req(FUNC_ACK, tnow, cur_seq, 1'($urandom),
                                         CLASS_W'($urandom));
                            end else if (c < 50) begin
                                send_req(FUNC_ACK, tnow, SEQ_W'($urandom), 1'($urandom),
                                         CLASS_W'($urandom));
                            end else begin
                                span = $urandom_range(1) ? send_v : ack_v;
                                tnow = tnow + TIMER_W'($urandom_range(0, 2 * span));
                                send_req(FUNC_POLL, tnow, SEQ_W'($urandom), 1'($urandom),
                                         CLASS_W'($urandom));
                            end
                            n++;
                        end
                    end
                end
            end
        end

        drain_results();
        if (fail_n == 0 && pending_n == 0) begin
            $display("[frame_tx_ack_retry_controller_top] OK");
        end else begin
            $display("[frame_tx_ack_retry_controller_top] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ftarc_pkg.sv
design/ftarc_req_if.sv
design/ftarc_res_if.sv
design/ftarc_ram.sv
design/frame_tx_ack_retry_controller_top.sv
verif/ftarc_tx_checker.sv
verif/tb_top.sv
